[sv/pdrf_pkg.sv]
// Package: shared constants, state and register codes for the domain region finder.
package pdrf_pkg;

   localparam int MAX_REGION   = 4096;
   localparam int MAX_POSITION = 65535;

   localparam int ADDR_W = $clog2(MAX_REGION);
   localparam int CNT_W  = $clog2(MAX_REGION + 2);
   localparam int PROB_W = 16;
   localparam int POS_W  = 16;
   localparam int SUM_W  = PROB_W + ADDR_W;
   localparam int LVL_W  = 16;
   localparam int MLVL_W = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [CNT_W-1:0] REGION_LIMIT = CNT_W'(MAX_REGION);
   localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_POSITION);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TRIGGER_LEVEL  = 2'd0,
      REG_BOUNDARY_LEVEL = 2'd1,
      REG_MULTI_LEVEL    = 2'd2
   } csr_index_type;

endpackage

[sv/pdrf_if.sv]
// Interfaces: position request channel and region response channel.
interface pdrf_req_if;
   logic                         valid;
   logic                         ready;
   logic [pdrf_pkg::PROB_W-1:0]  match_occ;
   logic [pdrf_pkg::PROB_W-1:0]  begin_prob;
   logic [pdrf_pkg::PROB_W-1:0]  end_prob;
   logic                         last;

   modport source (output valid, match_occ, begin_prob, end_prob, last, input ready);
   modport sink   (input valid, match_occ, begin_prob, end_prob, last, output ready);
endinterface

interface pdrf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pdrf_pkg::POS_W-1:0]   region_start;
   logic [pdrf_pkg::POS_W-1:0]   region_end;
   logic                         multidomain;
   logic                         too_long;

   modport source (output valid, region_start, region_end, multidomain, too_long,
                   input ready);
   modport sink   (input valid, region_start, region_end, multidomain, too_long,
                   output ready);
endinterface

[sv/posterior_domain_region_finder_top.sv]
// Top level: domain region finder over a stream of per-position posteriors.
//
// req_bus carries one residue position per word (occupancy, begin and end
// probability, last flag). rsp_bus carries one word per closed region: its
// 1-based bounds, a multidomain flag and a too_long flag. csr_we/csr_index/
// csr_data write the trigger, boundary and multidomain levels.
//
// A position that does not close a region leaves the block idle, so such
// positions stream at one per cycle. A closing position starts a walk over
// the buffered begin/end values of the region, one entry per cycle through a
// single memory read port and one accumulate/compare unit: req_bus.ready is
// low through the walk and the done state, and input resumes as the result
// word is loaded into the output register.
// If the receiver stalls, the block keeps accepting positions until the next
// region closes; that region's result then waits in the done state until
// the output register is free.
// Reset (synchronous) clears the sequence state, returns the levels to their
// defaults and drops any pending result. The buffer memory is not cleared:
// only entries written for the current region are ever read.
module posterior_domain_region_finder_top (
   input  logic                              clock,
   input  logic                              reset,
   pdrf_req_if.sink                          req_bus,
   pdrf_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [pdrf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdrf_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int AW = pdrf_pkg::ADDR_W;
   localparam int CW = pdrf_pkg::CNT_W;
   localparam int PW = pdrf_pkg::PROB_W;
   localparam int QW = pdrf_pkg::POS_W;
   localparam int SW = pdrf_pkg::SUM_W;

   pdrf_pkg::state_type state_ff, state_in;

   logic [pdrf_pkg::LVL_W-1:0]  trig_lvl_ff, bnd_lvl_ff;
   logic [pdrf_pkg::MLVL_W-1:0] multi_lvl_ff;

   logic [QW-1:0] position_ff, position_in;
   logic [QW-1:0] start_pos_ff, start_pos_in;
   logic          start_valid_ff, start_valid_in;
   logic          triggered_ff, triggered_in;
   logic [SW-1:0] bsum_ff, bsum_in;
   logic [CW-1:0] fill_ff, fill_in;

   logic [CW-1:0] walk_cnt_ff, walk_cnt_in;
   logic [SW-1:0] walk_bsum_ff, walk_bsum_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] ends_ff, ends_in;
   logic [SW-1:0] before_ff, before_in;
   logic [SW-1:0] best_ff, best_in;

   logic [QW-1:0] pend_start_ff, pend_start_in;
   logic [QW-1:0] pend_end_ff, pend_end_in;
   logic          pend_long_ff, pend_long_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [QW-1:0] rsp_start_ff, rsp_start_in;
   logic [QW-1:0] rsp_end_ff, rsp_end_in;
   logic          rsp_multi_ff, rsp_multi_in;
   logic          rsp_long_ff, rsp_long_in;

   logic [2*PW-1:0] mem [pdrf_pkg::MAX_REGION];
   logic [2*PW-1:0] rd_data_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [2*PW-1:0] mem_wdata;
   logic [AW-1:0]   mem_raddr;

   logic          accept;
   logic [PW+1:0] diff_b, diff_e;
   logic [PW+1:0] bnd_ext;
   logic          restart, too_long;
   logic [CW-1:0] base_cnt, new_cnt;
   logic [SW-1:0] base_sum, new_sum;
   logic [SW-1:0] ent_b, ent_e, ends_acc, after, split;
   logic          multi_hit;

   assign accept      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == pdrf_pkg::ST_IDLE);

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.region_start = rsp_start_ff;
   assign rsp_bus.region_end   = rsp_end_ff;
   assign rsp_bus.multidomain  = rsp_multi_ff;
   assign rsp_bus.too_long     = rsp_long_ff;

   assign diff_b  = {2'b00, req_bus.match_occ} - {2'b00, req_bus.begin_prob};
   assign diff_e  = {2'b00, req_bus.match_occ} - {2'b00, req_bus.end_prob};
   assign bnd_ext = {2'b00, bnd_lvl_ff};

   assign ent_b    = SW'(rd_data_ff[PW-1:0]);
   assign ent_e    = SW'(rd_data_ff[2*PW-1:PW]);
   assign ends_acc = ends_ff + ent_e;
   assign after    = walk_bsum_ff - before_ff;
   assign split    = (ends_acc < after) ? ends_acc : after;
   assign multi_hit = !pend_long_ff && (best_ff >= SW'(multi_lvl_ff));

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_lvl_ff  <= 16'd8192;
         bnd_lvl_ff   <= 16'd3277;
         multi_lvl_ff <= 18'd6554;
      end else if (csr_we) begin
         case (csr_index)
            pdrf_pkg::REG_TRIGGER_LEVEL:  trig_lvl_ff  <= csr_data[pdrf_pkg::LVL_W-1:0];
            pdrf_pkg::REG_BOUNDARY_LEVEL: bnd_lvl_ff   <= csr_data[pdrf_pkg::LVL_W-1:0];
            pdrf_pkg::REG_MULTI_LEVEL:    multi_lvl_ff <= csr_data[pdrf_pkg::MLVL_W-1:0];
            default: ;
         endcase
      end
   end

   // region buffer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pdrf_pkg::ST_IDLE;
         position_ff    <= '0;
         start_pos_ff   <= '0;
         start_valid_ff <= 1'b0;
         triggered_ff   <= 1'b0;
         bsum_ff        <= '0;
         fill_ff        <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         position_ff    <= position_in;
         start_pos_ff   <= start_pos_in;
         start_valid_ff <= start_valid_in;
         triggered_ff   <= triggered_in;
         bsum_ff        <= bsum_in;
         fill_ff        <= fill_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_cnt_ff   <= walk_cnt_in;
      walk_bsum_ff  <= walk_bsum_in;
      issue_ff      <= issue_in;
      ends_ff       <= ends_in;
      before_ff     <= before_in;
      best_ff       <= best_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff   <= pend_end_in;
      pend_long_ff  <= pend_long_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_multi_ff  <= rsp_multi_in;
      rsp_long_ff   <= rsp_long_in;
   end

   always_comb begin
      state_in       = state_ff;
      position_in    = position_ff;
      start_pos_in   = start_pos_ff;
      start_valid_in = start_valid_ff;
      triggered_in   = triggered_ff;
      bsum_in        = bsum_ff;
      fill_in        = fill_ff;
      walk_cnt_in    = walk_cnt_ff;
      walk_bsum_in   = walk_bsum_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      ends_in        = ends_ff;
      before_in      = before_ff;
      best_in        = best_ff;
      pend_start_in  = pend_start_ff;
      pend_end_in    = pend_end_ff;
      pend_long_in   = pend_long_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_start_in   = rsp_start_ff;
      rsp_end_in     = rsp_end_ff;
      rsp_multi_in   = rsp_multi_ff;
      rsp_long_in    = rsp_long_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = {req_bus.end_prob, req_bus.begin_prob};
      mem_raddr      = issue_ff[AW-1:0];
      restart        = 1'b0;
      too_long       = 1'b0;
      base_cnt       = fill_ff;
      base_sum       = bsum_ff;
      new_cnt        = fill_ff;
      new_sum        = bsum_ff;

      case (state_ff)
         pdrf_pkg::ST_IDLE: begin
            if (accept) begin
               if (position_ff != pdrf_pkg::POS_LIMIT) begin
                  position_in = position_ff + 1'b1;
               end
               if (!triggered_ff) begin
                  restart = ($signed(diff_b) < $signed(bnd_ext)) || !start_valid_ff;
                  if (restart) begin
                     base_cnt = '0;
                     base_sum = '0;
                  end
               end
               if (base_cnt < pdrf_pkg::REGION_LIMIT) begin
                  mem_we    = 1'b1;
                  mem_waddr = base_cnt[AW-1:0];
                  new_cnt   = base_cnt + 1'b1;
                  new_sum   = base_sum + SW'(req_bus.begin_prob);
               end else begin
                  new_cnt   = pdrf_pkg::REGION_LIMIT + 1'b1;
                  new_sum   = base_sum;
               end
               fill_in = new_cnt;
               bsum_in = new_sum;
               if (!triggered_ff) begin
                  if (restart) begin
                     start_pos_in   = position_in;
                     start_valid_in = 1'b1;
                  end
                  if (req_bus.match_occ >= trig_lvl_ff) begin
                     triggered_in = 1'b1;
                  end
               end else if ($signed(diff_e) < $signed(bnd_ext)) begin
                  too_long       = new_cnt > pdrf_pkg::REGION_LIMIT;
                  pend_start_in  = start_pos_ff;
                  pend_end_in    = position_in;
                  pend_long_in   = too_long;
                  walk_cnt_in    = too_long ? '0 : new_cnt;
                  walk_bsum_in   = new_sum;
                  issue_in       = '0;
                  ends_in        = '0;
                  before_in      = '0;
                  best_in        = '0;
                  start_valid_in = 1'b0;
                  triggered_in   = 1'b0;
                  fill_in        = '0;
                  bsum_in        = '0;
                  state_in       = pdrf_pkg::ST_WALK;
               end
               if (req_bus.last) begin
                  position_in    = '0;
                  start_pos_in   = '0;
                  start_valid_in = 1'b0;
                  triggered_in   = 1'b0;
                  fill_in        = '0;
                  bsum_in        = '0;
               end
            end
         end
         pdrf_pkg::ST_WALK: begin
            if (issue_ff < walk_cnt_ff) begin
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               ends_in   = ends_acc;
               before_in = before_ff + ent_b;
               if (split > best_ff) begin
                  best_in = split;
               end
            end
            if (issue_ff == walk_cnt_ff && !pend_ff) begin
               state_in = pdrf_pkg::ST_DONE;
            end
         end
         pdrf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = pend_start_ff;
               rsp_end_in   = pend_end_ff;
               rsp_multi_in = multi_hit;
               rsp_long_in  = pend_long_ff;
               state_in     = pdrf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[sv/pdrf_checker.sv]
// Checker: port-level assertions for the domain region finder, bound to the top.
module pdrf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pdrf_pkg::POS_W-1:0]    region_start,
   input logic [pdrf_pkg::POS_W-1:0]    region_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty and ready after reset");

   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a walk");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> region_start <= region_end)
      else $error("region start after region end");

endmodule

bind posterior_domain_region_finder_top pdrf_checker u_pdrf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .region_start (rsp_bus.region_start),
   .region_end   (rsp_bus.region_end)
);
